[design/mlhm_pkg.sv]
// ----------------------------------------------------------------------------
// mlhm_pkg
// Shared types, register codes and saturation helpers for the multilinear
// hysteretic material block.
// ----------------------------------------------------------------------------
package mlhm_pkg;

   localparam int SEGMENTS_DEF = 4;
   localparam int QUEUE_DEPTH  = 2;
   localparam int STRAIN_W     = 32;
   localparam int STRESS_W     = 48;
   localparam int WIDTH_W      = 31;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 48;

   localparam logic [CSR_IDX_W-1:0] REG_WIDTH0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SLOPE0 = 3'd4;

   localparam logic [1:0] MODE_TRIAL  = 2'd0;
   localparam logic [1:0] MODE_COMMIT = 2'd1;
   localparam logic [1:0] MODE_REVERT = 2'd2;
   localparam logic [1:0] MODE_START  = 2'd3;

   localparam logic [WIDTH_W-1:0]         WIDTH_RST = 31'd268435;
   localparam logic signed [STRESS_W-1:0] SLOPE_RST = 48'sd65536;

   localparam logic signed [55:0] MAX48 = 56'sd140737488355327;
   localparam logic signed [55:0] MIN48 = -56'sd140737488355328;
   localparam logic signed [35:0] MAX32 = 36'sd2147483647;
   localparam logic signed [35:0] MIN32 = -36'sd2147483648;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [31:0] strain;
   } req_type;

   function automatic logic signed [47:0] sat48(input logic signed [55:0] v);
      logic signed [47:0] r;
      if (v > MAX48) r = MAX48[47:0];
      else if (v < MIN48) r = MIN48[47:0];
      else r = v[47:0];
      return r;
   endfunction

   function automatic logic clip48(input logic signed [55:0] v);
      return (v > MAX48) || (v < MIN48);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      logic signed [31:0] r;
      if (v > MAX32) r = MAX32[31:0];
      else if (v < MIN32) r = MIN32[31:0];
      else r = v[31:0];
      return r;
   endfunction

endpackage

[design/mlhm_ifs.sv]
// ----------------------------------------------------------------------------
// mlhm request and response channels
// Valid/ready channels carrying one request word and one response word.
// ----------------------------------------------------------------------------
interface mlhm_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic signed [31:0] strain;
   modport source (output valid, mode, strain, input ready);
   modport sink (input valid, mode, strain, output ready);
endinterface

interface mlhm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [47:0] stress;
   logic signed [47:0] tangent;
   logic [1:0]         segment;
   logic               saturated;
   modport source (output valid, stress, tangent, segment, saturated, input ready);
   modport sink (input valid, stress, tangent, segment, saturated, output ready);
endinterface

[design/multilinear_hysteretic_material.sv]
// Work: a trial skips the multiply if the strain is unchanged, a revert
// needs none; commit (unless no yield) and revert to start step each segment.
// Throughput: one word at a time; the 4-stage multiply unit sets the cost
// of each segment step. A 2-word queue takes requests while one is at work.
// Reset: synchronous; trial and committed points clear to zero, registers
// to their defaults; segment bounds are valid only after a revert to start.
// ----------------------------------------------------------------------------
// multilinear_hysteretic_material
// Uniaxial multilinear material with kinematic hardening of its bounds.
// ----------------------------------------------------------------------------
module multilinear_hysteretic_material #(
   parameter int SEGMENTS = mlhm_pkg::SEGMENTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   mlhm_req_if.sink    req_ch,
   mlhm_rsp_if.source  rsp_ch,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_data
);

   logic [30:0]        width_ff [SEGMENTS];
   logic signed [47:0] slope_ff [SEGMENTS];
   logic               q_valid, q_pop;
   mlhm_pkg::req_type  q_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SEGMENTS; i++) begin
            width_ff[i] <= mlhm_pkg::WIDTH_RST;
            slope_ff[i] <= mlhm_pkg::SLOPE_RST;
         end
      end else if (csr_write) begin
         for (int i = 0; i < SEGMENTS; i++) begin
            if (csr_index == 3'(mlhm_pkg::REG_WIDTH0 + i)) width_ff[i] <= csr_data[30:0];
            if (csr_index == 3'(mlhm_pkg::REG_SLOPE0 + i)) slope_ff[i] <= $signed(csr_data);
         end
      end
   end

   mlhm_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_valid (q_valid),
      .q_pop   (q_pop),
      .q_item  (q_item)
   );

   mlhm_back #(.SEGMENTS(SEGMENTS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .width_seg (width_ff),
      .slope_seg (slope_ff),
      .rsp_ch    (rsp_ch)
   );

   a_pop_has_word: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("queue popped while empty");

   a_segment_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.segment <= 2'(SEGMENTS - 1))
      else $error("segment beyond configured count");

   a_reset_no_rsp: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid) else $error("response valid after reset");

endmodule

[design/mlhm_front.sv]
// ----------------------------------------------------------------------------
// mlhm_front
// Accepts request words and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module mlhm_front (
   input  logic             clock,
   input  logic             reset,
   mlhm_req_if.sink         req_ch,
   output logic             q_valid,
   input  logic             q_pop,
   output mlhm_pkg::req_type q_item
);

   localparam int PW = (mlhm_pkg::QUEUE_DEPTH > 1) ? $clog2(mlhm_pkg::QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(mlhm_pkg::QUEUE_DEPTH + 1);

   mlhm_pkg::req_type mem_ff [mlhm_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic push;

   assign req_ch.ready = (count_ff != CW'(mlhm_pkg::QUEUE_DEPTH));
   assign push         = req_ch.valid && req_ch.ready;
   assign q_valid      = (count_ff != '0);
   assign q_item       = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff].mode   <= req_ch.mode;
         mem_ff[wr_ptr_ff].strain <= req_ch.strain;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(mlhm_pkg::QUEUE_DEPTH - 1)) ? '0 : PW'(wr_ptr_ff + 1'b1);
         end
         if (q_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(mlhm_pkg::QUEUE_DEPTH - 1)) ? '0 : PW'(rd_ptr_ff + 1'b1);
         end
         if (push && !q_pop) count_ff <= CW'(count_ff + 1'b1);
         else if (!push && q_pop) count_ff <= CW'(count_ff - 1'b1);
      end
   end

endmodule

[design/mlhm_mac.sv]
// ----------------------------------------------------------------------------
// mlhm_mac
// Four-stage multiply-accumulate: base + trunc((a * b) >> 28), saturated
// to 48 bits, product split into two 24-bit halves of b.
// ----------------------------------------------------------------------------
module mlhm_mac (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [33:0] a_in,
   input  logic signed [47:0] b_in,
   input  logic signed [47:0] base_in,
   output logic               done,
   output logic signed [47:0] res,
   output logic               clip
);

   logic [3:0]         vld_ff;
   logic [33:0]        ua_ff;
   logic [47:0]        ub_ff;
   logic [2:1]         neg_ff;
   logic signed [47:0] base1_ff, base2_ff, base3_ff;
   logic [57:0]        plo_ff, phi_ff;
   logic signed [54:0] rs_ff;
   logic signed [47:0] res_ff;
   logic               clip_ff;
   logic [81:0]        sum_full;
   logic [54:0]        mag;
   logic signed [55:0] acc;

   assign sum_full = 82'({phi_ff, 24'b0}) + 82'(plo_ff);
   assign mag      = {1'b0, sum_full[81:28]};
   assign acc      = 56'(base3_ff) + 56'(rs_ff);

   always_ff @(posedge clock) begin
      ua_ff    <= a_in[33] ? 34'(-a_in) : a_in;
      ub_ff    <= b_in[47] ? 48'(-b_in) : b_in;
      neg_ff[1] <= a_in[33] ^ b_in[47];
      base1_ff <= base_in;
      plo_ff   <= 58'(ua_ff) * 58'(ub_ff[23:0]);
      phi_ff   <= 58'(ua_ff) * 58'(ub_ff[47:24]);
      neg_ff[2] <= neg_ff[1];
      base2_ff <= base1_ff;
      rs_ff    <= neg_ff[2] ? -$signed(mag) : $signed(mag);
      base3_ff <= base2_ff;
      res_ff   <= mlhm_pkg::sat48(acc);
      clip_ff  <= mlhm_pkg::clip48(acc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[2:0], start};
      end
   end

   assign done = vld_ff[3];
   assign res  = res_ff;
   assign clip = clip_ff;

endmodule

[design/mlhm_back.sv]
// ----------------------------------------------------------------------------
// mlhm_back
// Sequencer that carries out trial, commit, revert and rebuild, holding the
// segment bounds and the trial and committed points.
// ----------------------------------------------------------------------------
module mlhm_back #(
   parameter int SEGMENTS = mlhm_pkg::SEGMENTS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  mlhm_pkg::req_type        q_item,
   output logic                     q_pop,
   input  logic [30:0]              width_seg [SEGMENTS],
   input  logic signed [47:0]       slope_seg [SEGMENTS],
   mlhm_rsp_if.source               rsp_ch
);

   localparam int IW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_TR_MUL  = 4'd1;
   localparam logic [3:0] S_TR_WAIT = 4'd2;
   localparam logic [3:0] S_CM_ADD  = 4'd3;
   localparam logic [3:0] S_CM_MUL  = 4'd4;
   localparam logic [3:0] S_CM_WAIT = 4'd5;
   localparam logic [3:0] S_RB_MUL  = 4'd6;
   localparam logic [3:0] S_RB_WAIT = 4'd7;
   localparam logic [3:0] S_RB_NEG  = 4'd8;
   localparam logic [3:0] S_FIN     = 4'd9;

   logic [3:0] state_ff;

   logic signed [31:0] lo_strain_ff [SEGMENTS];
   logic signed [31:0] up_strain_ff [SEGMENTS];
   logic signed [47:0] lo_stress_ff [SEGMENTS];
   logic signed [47:0] up_stress_ff [SEGMENTS];

   logic signed [31:0] trial_strain_ff, comm_strain_ff;
   logic signed [47:0] trial_stress_ff, comm_stress_ff;
   logic signed [47:0] trial_tangent_ff, comm_tangent_ff;
   logic [1:0]         active_ff;
   logic               clip_ff;

   logic signed [31:0] x_ff;
   logic [IW-1:0]      idx_ff, seg_ff;
   logic               upper_side_ff;
   logic signed [31:0] prev_n_ff, prev_f_ff, fnew_ff;
   logic signed [47:0] prev_fs_ff;

   logic               rsp_valid_ff;
   logic signed [47:0] rsp_stress_ff, rsp_tangent_ff;
   logic [1:0]         rsp_segment_ff;
   logic               rsp_sat_ff;

   logic signed [31:0] xq;
   logic               below, above;
   logic [IW-1:0]      s_lo, s_up, s_pick;
   logic               last, in_near;
   logic signed [31:0] n_cur;
   logic [31:0]        w2u;
   logic signed [33:0] sw2;
   logic               mac_start, mac_done, mac_clip;
   logic signed [33:0] mac_a;
   logic signed [47:0] mac_b, mac_base, mac_res;
   logic signed [55:0] neg_fs;

   assign xq = $signed(q_item.strain);

   always_comb begin
      below  = xq < lo_strain_ff[0];
      above  = !below && (xq > up_strain_ff[0]);
      s_lo   = IW'(SEGMENTS - 1);
      s_up   = IW'(SEGMENTS - 1);
      for (int k = SEGMENTS - 1; k >= 1; k--) begin
         if (!(xq < lo_strain_ff[k])) s_lo = IW'(k);
         if (!(xq > up_strain_ff[k])) s_up = IW'(k);
      end
      if (below) s_pick = s_lo;
      else if (above) s_pick = s_up;
      else s_pick = '0;
   end

   assign last    = (idx_ff == IW'(SEGMENTS - 1));
   assign in_near = (idx_ff < seg_ff);
   assign n_cur   = upper_side_ff ? up_strain_ff[idx_ff] : lo_strain_ff[idx_ff];
   assign w2u     = {width_seg[idx_ff], 1'b0};
   assign sw2     = upper_side_ff ? -$signed({2'b00, w2u}) : $signed({2'b00, w2u});
   assign neg_fs  = -56'(prev_fs_ff);
   assign q_pop   = (state_ff == S_IDLE) && q_valid;

   always_comb begin
      mac_start = 1'b0;
      mac_a     = '0;
      mac_b     = slope_seg[idx_ff];
      mac_base  = prev_fs_ff;
      unique case (state_ff)
         S_TR_MUL: begin
            mac_start = 1'b1;
            if (upper_side_ff) begin
               mac_a    = 34'(x_ff) - 34'(up_strain_ff[idx_ff]);
               mac_base = up_stress_ff[idx_ff];
            end else begin
               mac_a    = 34'(x_ff) - 34'(lo_strain_ff[idx_ff]);
               mac_base = lo_stress_ff[idx_ff];
            end
         end
         S_CM_MUL: begin
            mac_start = 1'b1;
            mac_a     = in_near ? sw2 : 34'(fnew_ff) - 34'(prev_f_ff);
         end
         S_RB_MUL: begin
            mac_start = 1'b1;
            mac_a     = $signed({3'b000, width_seg[idx_ff]});
         end
         default: begin
            mac_start = 1'b0;
         end
      endcase
   end

   mlhm_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .start   (mac_start),
      .a_in    (mac_a),
      .b_in    (mac_b),
      .base_in (mac_base),
      .done    (mac_done),
      .res     (mac_res),
      .clip    (mac_clip)
   );

   // datapath and bound storage
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               x_ff   <= xq;
               idx_ff <= (q_item.mode == mlhm_pkg::MODE_TRIAL) ? s_pick : '0;
               unique case (q_item.mode)
                  mlhm_pkg::MODE_TRIAL: begin
                     upper_side_ff <= above;
                  end
                  mlhm_pkg::MODE_COMMIT: begin
                     seg_ff        <= active_ff[IW-1:0];
                     upper_side_ff <= trial_strain_ff > up_strain_ff[0];
                     prev_f_ff     <= trial_strain_ff;
                     prev_fs_ff    <= trial_stress_ff;
                  end
                  mlhm_pkg::MODE_REVERT: begin
                     prev_n_ff <= prev_n_ff;
                  end
                  mlhm_pkg::MODE_START: begin
                     prev_n_ff  <= '0;
                     prev_fs_ff <= '0;
                  end
               endcase
            end
         end
         S_CM_ADD: begin
            if (in_near) begin
               fnew_ff <= mlhm_pkg::sat32(36'(prev_f_ff) + 36'(sw2));
               if (upper_side_ff) begin
                  up_strain_ff[idx_ff] <= trial_strain_ff;
                  up_stress_ff[idx_ff] <= trial_stress_ff;
               end else begin
                  lo_strain_ff[idx_ff] <= trial_strain_ff;
                  lo_stress_ff[idx_ff] <= trial_stress_ff;
               end
            end else begin
               fnew_ff <= mlhm_pkg::sat32(36'(prev_f_ff) + 36'(sw2) + 36'(n_cur)
                                          - 36'(prev_n_ff));
            end
         end
         S_CM_WAIT: begin
            if (mac_done) begin
               if (upper_side_ff) begin
                  lo_strain_ff[idx_ff] <= fnew_ff;
                  lo_stress_ff[idx_ff] <= mac_res;
               end else begin
                  up_strain_ff[idx_ff] <= fnew_ff;
                  up_stress_ff[idx_ff] <= mac_res;
               end
               prev_f_ff  <= fnew_ff;
               prev_fs_ff <= mac_res;
               prev_n_ff  <= in_near ? trial_strain_ff : n_cur;
               if (!last) idx_ff <= IW'(idx_ff + 1'b1);
            end
         end
         S_RB_MUL: begin
            fnew_ff <= mlhm_pkg::sat32(36'(prev_n_ff) + 36'({1'b0, width_seg[idx_ff]}));
         end
         S_RB_WAIT: begin
            if (mac_done) begin
               up_strain_ff[idx_ff] <= fnew_ff;
               up_stress_ff[idx_ff] <= mac_res;
               prev_n_ff            <= fnew_ff;
               prev_fs_ff           <= mac_res;
            end
         end
         S_RB_NEG: begin
            lo_strain_ff[idx_ff] <= mlhm_pkg::sat32(-36'(fnew_ff));
            lo_stress_ff[idx_ff] <= mlhm_pkg::sat48(neg_fs);
            if (!last) idx_ff <= IW'(idx_ff + 1'b1);
         end
         default: begin
            x_ff <= x_ff;
         end
      endcase
   end

   // control, trial and committed point
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         trial_strain_ff  <= '0;
         trial_stress_ff  <= '0;
         trial_tangent_ff <= '0;
         comm_strain_ff   <= '0;
         comm_stress_ff   <= '0;
         comm_tangent_ff  <= '0;
         active_ff        <= '0;
         clip_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (rsp_ch.ready && (state_ff != S_FIN)) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  clip_ff <= 1'b0;
                  unique case (q_item.mode)
                     mlhm_pkg::MODE_TRIAL: begin
                        state_ff <= (xq == trial_strain_ff) ? S_FIN : S_TR_MUL;
                     end
                     mlhm_pkg::MODE_COMMIT: begin
                        if (active_ff == 2'd0) begin
                           comm_strain_ff  <= trial_strain_ff;
                           comm_stress_ff  <= trial_stress_ff;
                           comm_tangent_ff <= trial_tangent_ff;
                           state_ff        <= S_FIN;
                        end else begin
                           state_ff <= S_CM_ADD;
                        end
                     end
                     mlhm_pkg::MODE_REVERT: begin
                        trial_strain_ff  <= comm_strain_ff;
                        trial_stress_ff  <= comm_stress_ff;
                        trial_tangent_ff <= comm_tangent_ff;
                        active_ff        <= '0;
                        state_ff         <= S_FIN;
                     end
                     mlhm_pkg::MODE_START: begin
                        state_ff <= S_RB_MUL;
                     end
                  endcase
               end
            end
            S_TR_MUL: state_ff <= S_TR_WAIT;
            S_TR_WAIT: begin
               if (mac_done) begin
                  trial_strain_ff  <= x_ff;
                  trial_stress_ff  <= mac_res;
                  trial_tangent_ff <= slope_seg[idx_ff];
                  active_ff        <= 2'(idx_ff);
                  clip_ff          <= clip_ff | mac_clip;
                  state_ff         <= S_FIN;
               end
            end
            S_CM_ADD: state_ff <= S_CM_MUL;
            S_CM_MUL: state_ff <= S_CM_WAIT;
            S_CM_WAIT: begin
               if (mac_done) begin
                  clip_ff <= clip_ff | mac_clip;
                  if (last) begin
                     active_ff       <= '0;
                     comm_strain_ff  <= trial_strain_ff;
                     comm_stress_ff  <= trial_stress_ff;
                     comm_tangent_ff <= trial_tangent_ff;
                     state_ff        <= S_FIN;
                  end else begin
                     state_ff <= S_CM_ADD;
                  end
               end
            end
            S_RB_MUL: state_ff <= S_RB_WAIT;
            S_RB_WAIT: begin
               if (mac_done) begin
                  clip_ff  <= clip_ff | mac_clip;
                  state_ff <= S_RB_NEG;
               end
            end
            S_RB_NEG: begin
               clip_ff <= clip_ff | mlhm_pkg::clip48(neg_fs);
               if (last) begin
                  trial_strain_ff  <= '0;
                  comm_strain_ff   <= '0;
                  trial_stress_ff  <= '0;
                  comm_stress_ff   <= '0;
                  trial_tangent_ff <= slope_seg[0];
                  comm_tangent_ff  <= slope_seg[0];
                  active_ff        <= '0;
                  state_ff         <= S_FIN;
               end else begin
                  state_ff <= S_RB_MUL;
               end
            end
            S_FIN: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_stress_ff  <= trial_stress_ff;
                  rsp_tangent_ff <= trial_tangent_ff;
                  rsp_segment_ff <= active_ff;
                  rsp_sat_ff     <= clip_ff;
                  state_ff       <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.stress    = rsp_stress_ff;
   assign rsp_ch.tangent   = rsp_tangent_ff;
   assign rsp_ch.segment   = rsp_segment_ff;
   assign rsp_ch.saturated = rsp_sat_ff;

endmodule
